FILE: hw/rtl/mvm_pkg.sv
// Package for the matrix-vector multiply engine: payload structs and sequencer states.
// Used by the channel interfaces and by matrix_vector_multiply_top.
`default_nettype none

package mvm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } seq_state_type;

   // Register indexes of the configuration port
   localparam logic CSR_ROWS_IN_USE = 1'b0;
   localparam logic CSR_COLS_IN_USE = 1'b1;

   localparam logic OP_WEIGHT = 1'b0;
   localparam logic OP_VECTOR = 1'b1;

   localparam logic [4:0] ROWS_RESET = 5'd16;
   localparam logic [6:0] COLS_RESET = 7'd64;

   typedef struct packed {
      logic              opcode;
      logic [3:0]        row_sel;
      logic [5:0]        col_sel;
      logic signed [15:0] value;
      logic              last_element;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]         out_row;
      logic signed [39:0] product;
      logic               last_row;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: hw/rtl/mvm_req_if.sv
// Input channel of the matrix-vector multiply engine: valid, ready and one load item.
// Depends on mvm_pkg for the payload struct.
`default_nettype none

interface mvm_req_if;
   import mvm_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mvm_rsp_if.sv
// Result channel of the matrix-vector multiply engine: valid, ready and one row result.
// Depends on mvm_pkg for the payload struct.
`default_nettype none

interface mvm_rsp_if;
   import mvm_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/matrix_vector_multiply_top.sv
// Top level of the dense matrix-vector multiply engine: stores, sequencer, MAC pipeline.
// Depends on mvm_pkg, mvm_req_if and mvm_rsp_if.
`default_nettype none

// Weight and vector load items are taken one per cycle while the engine is idle and are
// written straight into two memories (MAX_ROWS*MAX_COLS and MAX_COLS entries
// of 16 bits, contents undefined until written; no clearing pass after reset). A vector
// item marked last starts a run: the sequencer reads one weight and one vector element
// per cycle while the pipeline is not frozen and feeds a single 16x16 multiply-accumulate;
// the one read port of the weight memory sets this pace. A result that waits in the output
// register freezes the pipeline until it is taken. Loads are not accepted during a run;
// they resume once the sequencer is back in idle after the last row result has reached
// the output register.
module matrix_vector_multiply_top #(
   parameter int MAX_ROWS = 16,
   parameter int MAX_COLS = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   mvm_req_if.sink         req_chan,
   mvm_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_index,
   input  wire logic [6:0] csr_wr_data
);
   import mvm_pkg::*;

   localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIDX_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int WDEPTH  = MAX_ROWS * MAX_COLS;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

   // Configuration
   logic [4:0] rows_cfg_ff;
   logic [6:0] cols_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= ROWS_RESET;
         cols_cfg_ff <= COLS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_cfg_ff <= csr_wr_data[4:0];
            CSR_COLS_IN_USE: cols_cfg_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Clamp the counts to 1..MAX and keep the index of the final row and column
   logic [31:0] nrows;
   logic [31:0] ncols;
   logic [31:0] nrows_m1;
   logic [31:0] ncols_m1;

   always_comb begin
      priority if (rows_cfg_ff == 5'd0) nrows = 32'd1;
      else if (32'(rows_cfg_ff) > 32'(MAX_ROWS)) nrows = 32'(MAX_ROWS);
      else nrows = 32'(rows_cfg_ff);
      priority if (cols_cfg_ff == 7'd0) ncols = 32'd1;
      else if (32'(cols_cfg_ff) > 32'(MAX_COLS)) ncols = 32'(MAX_COLS);
      else ncols = 32'(cols_cfg_ff);
      nrows_m1 = nrows - 32'd1;
      ncols_m1 = ncols - 32'd1;
   end

   logic [RIDX_W-1:0] last_r;
   logic [CIDX_W-1:0] last_c;
   assign last_r = nrows_m1[RIDX_W-1:0];
   assign last_c = ncols_m1[CIDX_W-1:0];

   // Handshake and sequencer
   seq_state_type state_ff, state_in;
   logic          rsp_valid_ff;
   logic          advance;
   logic          accept;
   logic          trigger;
   logic          issue;
   logic          s1_valid_ff;
   logic          s2_valid_ff;
   logic [RIDX_W-1:0] row_ff;
   logic [CIDX_W-1:0] col_ff;
   logic          end_of_run;

   // Freeze the pipeline while a result waits to be taken
   assign advance    = !rsp_valid_ff || rsp_chan.ready;
   assign accept     = req_chan.valid && req_chan.ready;
   assign trigger    = accept && (req_chan.payload.opcode == OP_VECTOR) &&
                       req_chan.payload.last_element;
   assign end_of_run = (row_ff == last_r) && (col_ff == last_c);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      issue          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (trigger) state_in = ST_RUN;
         end
         ST_RUN: begin
            issue = advance;
            if (advance && end_of_run) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (trigger) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (issue) begin
         if (col_ff == last_c) begin
            col_ff <= '0;
            row_ff <= row_ff + RIDX_W'(1);
         end else begin
            col_ff <= col_ff + CIDX_W'(1);
         end
      end
   end

   // Memories
   logic [31:0]        w_waddr32;
   logic [31:0]        w_raddr32;
   logic [31:0]        v_idx32;
   logic               wr_weight;
   logic               wr_vector;
   logic signed [15:0] weight_mem_ff [WDEPTH];
   logic signed [15:0] vector_mem_ff [MAX_COLS];
   logic signed [15:0] w_rd_ff;
   logic signed [15:0] v_rd_ff;

   assign w_waddr32 = 32'(req_chan.payload.row_sel) * 32'(MAX_COLS)
                    + 32'(req_chan.payload.col_sel);
   assign w_raddr32 = 32'(row_ff) * 32'(MAX_COLS) + 32'(col_ff);
   assign v_idx32   = 32'(req_chan.payload.col_sel);

   // Drop writes that fall outside the stores
   assign wr_weight = accept && (req_chan.payload.opcode == OP_WEIGHT) &&
                      (32'(req_chan.payload.row_sel) < 32'(MAX_ROWS)) &&
                      (v_idx32 < 32'(MAX_COLS));
   assign wr_vector = accept && (req_chan.payload.opcode == OP_VECTOR) &&
                      (v_idx32 < 32'(MAX_COLS));

   always_ff @(posedge clock) begin
      if (wr_weight) weight_mem_ff[w_waddr32[WADDR_W-1:0]] <= req_chan.payload.value;
      if (advance)   w_rd_ff <= weight_mem_ff[w_raddr32[WADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_vector) vector_mem_ff[v_idx32[CIDX_W-1:0]] <= req_chan.payload.value;
      if (advance)   v_rd_ff <= vector_mem_ff[col_ff];
   end

   // MAC pipeline: read data, product, accumulate
   logic              s1_first_ff, s1_lastcol_ff, s1_lastrow_ff;
   logic [RIDX_W-1:0] s1_row_ff;
   logic              s2_first_ff, s2_lastcol_ff, s2_lastrow_ff;
   logic [RIDX_W-1:0] s2_row_ff;
   logic signed [31:0] prod_ff;
   logic signed [39:0] acc_ff;
   logic signed [39:0] acc_in;
   logic [31:0]        s2_row32;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_first_ff   <= (col_ff == '0);
         s1_lastcol_ff <= (col_ff == last_c);
         s1_lastrow_ff <= (row_ff == last_r);
         s1_row_ff     <= row_ff;
         s2_first_ff   <= s1_first_ff;
         s2_lastcol_ff <= s1_lastcol_ff;
         s2_lastrow_ff <= s1_lastrow_ff;
         s2_row_ff     <= s1_row_ff;
         prod_ff       <= w_rd_ff * v_rd_ff;
      end
   end

   assign acc_in   = (s2_first_ff ? 40'sd0 : acc_ff) + {{8{prod_ff[31]}}, prod_ff};
   assign s2_row32 = 32'(s2_row_ff);

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) acc_ff <= acc_in;
   end

   // Output register
   rsp_payload_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && s2_valid_ff && s2_lastcol_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff && s2_lastcol_ff) begin
         rsp_payload_ff.out_row  <= s2_row32[3:0];
         rsp_payload_ff.product  <= acc_in;
         rsp_payload_ff.last_row <= s2_lastrow_ff;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

`ifndef SYNTHESIS
   a_stall_holds_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && !trigger) |=>
         ($stable(acc_ff) && $stable(row_ff) && $stable(col_ff)))
      else $error("MAC pipeline moved while a result was stalled");

   a_row_end_loads_out: assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_lastcol_ff) |=> rsp_valid_ff)
      else $error("finished row did not reach the output register");

   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_valid_ff && !s2_valid_ff))
      else $error("MAC pipeline busy while loads are accepted");

   a_trigger_starts_run: assert property (@(posedge clock) disable iff (reset)
      trigger |=> (state_ff == ST_RUN && row_ff == '0 && col_ff == '0))
      else $error("run did not start at row and column zero");
`endif

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for matrix_vector_multiply_top: directed table, then random load
// sequences, with results predicted in-bench and compared per field in arrival order.
// Depends on mvm_pkg, mvm_req_if and mvm_rsp_if.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mvm_pkg::*;

   localparam int NUM_ROWS         = 16;
   localparam int COL_COUNT        = 64;
   localparam int LOAD_TARGET      = 160;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int CYCLE_LIMIT      = 400000;

   typedef struct packed {
      bit                 is_csr;
      logic               csr_sel;
      logic [6:0]         csr_val;
      req_payload_type    load;
      bit                 known;
      logic signed [39:0] known_product;
   } plan_step_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = 1'b0;
   logic [6:0] csr_wr_data = '0;

   mvm_req_if req_chan();
   mvm_rsp_if rsp_chan();

   matrix_vector_multiply_top #(
      .MAX_ROWS(NUM_ROWS),
      .MAX_COLS(COL_COUNT)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the engine's stores and registers
   logic signed [15:0] weight_mem [NUM_ROWS][COL_COUNT];
   logic signed [15:0] vector_mem [COL_COUNT];
   bit                 weight_loaded [NUM_ROWS][COL_COUNT];
   bit                 vector_loaded [COL_COUNT];
   logic [4:0]         rows_reg = ROWS_RESET;
   logic [6:0]         cols_reg = COLS_RESET;

   rsp_payload_type row_results_due[$];
   bit              failed = 1'b0;
   bit              req_quiet = 1'b0;
   bit              rsp_quiet = 1'b0;
   bit              long_hold_armed = 1'b0;
   int unsigned     loads_sent = 0;
   int unsigned     cycle_count = 0;

   function automatic int active_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > NUM_ROWS) return NUM_ROWS;
      return int'(rows_reg);
   endfunction

   function automatic int active_cols();
      if (cols_reg == 0) return 1;
      if (cols_reg > COL_COUNT) return COL_COUNT;
      return int'(cols_reg);
   endfunction

   function automatic void predict_row_products();
      rsp_payload_type res;
      longint          acc;
      int              nr;
      int              nc;
      nr = active_rows();
      nc = active_cols();
      for (int r = 0; r < nr; r++) begin
         acc = 0;
         for (int c = 0; c < nc; c++)
            acc += longint'(weight_mem[r][c]) * longint'(vector_mem[c]);
         res.out_row  = r[3:0];
         res.product  = acc[39:0];
         res.last_row = (r == nr - 1);
         row_results_due.push_back(res);
      end
   endfunction

   function automatic void record_load(req_payload_type ld, bit known,
                                       logic signed [39:0] known_product);
      rsp_payload_type res;
      if (ld.opcode == OP_WEIGHT) begin
         // a last mark on a weight item is ignored
         weight_mem[ld.row_sel][ld.col_sel] = ld.value;
         weight_loaded[ld.row_sel][ld.col_sel] = 1'b1;
      end else begin
         vector_mem[ld.col_sel] = ld.value;
         vector_loaded[ld.col_sel] = 1'b1;
         if (ld.last_element) begin
            if (known) begin
               res.out_row  = 4'd0;
               res.product  = known_product;
               res.last_row = 1'b1;
               row_results_due.push_back(res);
            end else begin
               predict_row_products();
            end
         end
      end
   endfunction

   function automatic void check_result(rsp_payload_type got);
      rsp_payload_type want;
      if (row_results_due.size() == 0) begin
         $error("unexpected result: out_row %0d product %0d", got.out_row, got.product);
         failed = 1'b1;
         return;
      end
      want = row_results_due.pop_front();
      if (got.out_row !== want.out_row) begin
         $error("out_row expected %0d got %0d", want.out_row, got.out_row);
         failed = 1'b1;
      end
      if (got.product !== want.product) begin
         $error("product expected %0d got %0d", want.product, got.product);
         failed = 1'b1;
      end
      if (got.last_row !== want.last_row) begin
         $error("last_row expected %0d got %0d", want.last_row, got.last_row);
         failed = 1'b1;
      end
   endfunction

   function automatic logic [15:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_payload_type make_load(logic op, int row, int col,
                                                 logic [15:0] val, logic last);
      req_payload_type ld;
      ld.opcode       = op;
      ld.row_sel      = row[3:0];
      ld.col_sel      = col[5:0];
      ld.value        = val;
      ld.last_element = last;
      return ld;
   endfunction

   function automatic plan_step_type load_step(logic op, int row, int col, logic [15:0] val,
                                               logic last, bit known = 1'b0,
                                               logic signed [39:0] known_product = '0);
      plan_step_type s;
      s = '0;
      s.load          = make_load(op, row, col, val, last);
      s.known         = known;
      s.known_product = known_product;
      return s;
   endfunction

   function automatic plan_step_type csr_step(logic sel, logic [6:0] val);
      plan_step_type s;
      s = '0;
      s.is_csr  = 1'b1;
      s.csr_sel = sel;
      s.csr_val = val;
      return s;
   endfunction

   task automatic send_load(req_payload_type ld, bit known = 1'b0,
                            logic signed [39:0] known_product = '0);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= ld;
      do @(posedge clock); while (!req_chan.ready);
      record_load(ld, known, known_product);
      loads_sent++;
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_chan.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      drop_valid();
      while (row_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic sel, logic [6:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= sel;
      csr_wr_data <= val;
      @(posedge clock);
      if (sel == CSR_ROWS_IN_USE) rows_reg = val[4:0];
      else cols_reg = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One well-formed run: partial loads, fill of every entry the run reads, then the trigger
   task automatic run_sequence();
      int nr;
      int nc;
      int n;
      nr = active_rows();
      nc = active_cols();
      if ($urandom_range(0, 3) != 0) begin
         n = $urandom_range(0, 12);
         repeat (n) begin
            if ($urandom_range(0, 7) == 0)
               send_load(make_load(OP_WEIGHT, $urandom_range(0, 15), $urandom_range(0, 63),
                                   rand_value(), 1'($urandom_range(0, 1))));
            else
               send_load(make_load(OP_WEIGHT, $urandom_range(0, nr - 1),
                                   $urandom_range(0, nc - 1), rand_value(),
                                   $urandom_range(0, 15) == 0));
         end
      end
      n = $urandom_range(0, (nc < 8) ? nc : 8);
      repeat (n)
         send_load(make_load(OP_VECTOR, $urandom_range(0, 15),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, nc - 1),
                             rand_value(), 1'b0));
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nc; c++)
            if (!weight_loaded[r][c])
               send_load(make_load(OP_WEIGHT, r, c, rand_value(), 1'b0));
      for (int c = 0; c < nc; c++)
         if (!vector_loaded[c])
            send_load(make_load(OP_VECTOR, $urandom_range(0, 15), c, rand_value(), 1'b0));
      send_load(make_load(OP_VECTOR, $urandom_range(0, 15),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, nc - 1),
                          rand_value(), 1'b1));
   endtask

   // Result side: random stall per item, one long hold when armed
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         if (long_hold_armed) begin
            long_hold_armed = 1'b0;
            stall = LONG_HOLD_CYCLES;
         end else begin
            stall = rsp_quiet ? 0 : $urandom_range(0, 19);
         end
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid || reset);
         check_result(rsp_chan.payload);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      plan_step_type plan[$];
      logic [6:0]    rows_data;
      logic [6:0]    cols_data;
      int            phase;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;

      plan.push_back(csr_step(CSR_ROWS_IN_USE, 7'd1));
      plan.push_back(csr_step(CSR_COLS_IN_USE, 7'd1));
      plan.push_back(load_step(OP_WEIGHT, 0, 0, 16'h7FFF, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'h7FFF, 1'b1, 1'b1, 1073676289));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'h8000, 1'b1, 1'b1, -1073709056));
      plan.push_back(load_step(OP_WEIGHT, 0, 0, 16'h8000, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'h8000, 1'b1, 1'b1, 1073741824));
      // last mark on a weight item writes the entry and starts nothing
      plan.push_back(load_step(OP_WEIGHT, 0, 0, 16'h1000, 1'b1));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'h1000, 1'b1, 1'b1, 16777216));
      plan.push_back(load_step(OP_VECTOR, 0, 5, 16'h7FFF, 1'b0));
      // zero column count acts as one
      plan.push_back(csr_step(CSR_COLS_IN_USE, 7'd0));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'hF000, 1'b1, 1'b1, -16777216));
      plan.push_back(csr_step(CSR_ROWS_IN_USE, 7'd0));
      plan.push_back(load_step(OP_WEIGHT, 0, 0, 16'h0001, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'h0001, 1'b1, 1'b1, 1));
      plan.push_back(csr_step(CSR_COLS_IN_USE, 7'd2));
      plan.push_back(load_step(OP_WEIGHT, 0, 1, 16'h7FFF, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 0, 1, 16'h7FFF, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 0, 0, 16'h8000, 1'b1));
      plan.push_back(csr_step(CSR_ROWS_IN_USE, 7'd2));
      plan.push_back(load_step(OP_WEIGHT, 1, 0, 16'h8000, 1'b0));
      plan.push_back(load_step(OP_WEIGHT, 1, 1, 16'h8000, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 0, 1, 16'h8000, 1'b1));
      plan.push_back(load_step(OP_WEIGHT, 15, 63, 16'h5A5A, 1'b0));
      plan.push_back(load_step(OP_VECTOR, 9, 63, 16'hA5A5, 1'b1));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         req_quiet = ($urandom_range(0, 1) == 1);
         rsp_quiet = ($urandom_range(0, 1) == 1);
         if (plan[i].is_csr) begin
            wait_idle();
            write_csr(plan[i].csr_sel, plan[i].csr_val);
         end else begin
            send_load(plan[i].load, plan[i].known, plan[i].known_product);
         end
      end

      loads_sent = 0;
      phase = 0;
      while (phase < 4 || loads_sent < LOAD_TARGET) begin
         case (phase)
            0: begin rows_data = 7'd1;   cols_data = 7'd64;  end
            1: begin rows_data = 7'd16;  cols_data = 7'd1;   end
            // rows field keeps five bits: saturates to the full row count
            2: begin rows_data = 7'h7F;  cols_data = 7'd2;   end
            3: begin rows_data = 7'd0;   cols_data = 7'd127; end
            default: begin
               rows_data = 7'($urandom_range(0, 31));
               cols_data = 7'($urandom_range(0, 12));
            end
         endcase
         wait_idle();
         write_csr(CSR_ROWS_IN_USE, rows_data);
         write_csr(CSR_COLS_IN_USE, cols_data);
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         // hold the result side during a multi-row run while the next loads wait for the engine
         if (phase == 1) long_hold_armed = 1'b1;
         repeat ((phase == 1) ? 2 : $urandom_range(1, 2)) run_sequence();
         phase++;
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/mvm_pkg.sv
hw/rtl/mvm_req_if.sv
hw/rtl/mvm_rsp_if.sv
hw/rtl/matrix_vector_multiply_top.sv
test/testbench.sv
